// ===== rtl/cpcr_pkg.sv =====
// Shared constants and small arithmetic helpers for the circle pair collision response unit.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cpcr_pkg;

  localparam int unsigned IN_TDATA_W  = 384;
  localparam int unsigned OUT_TDATA_W = 128;

  // Overlap test: 10000*d^2 <= 9801*(ra+rb)^2, i.e. d <= 0.99*(ra+rb).
  localparam logic [13:0] K_DIST = 14'd10000;
  localparam logic [13:0] K_RAD  = 14'd9801;

  // Pairs of radicand bits taken by the square root, and quotient bits of the momentum divide.
  localparam int unsigned SQ_STEPS = 31;
  localparam int unsigned HD_STEPS = 41;

  // Magnitude bound on a handed-over velocity term.
  localparam logic [40:0] HAND_LIM = 41'h100_0000_0000;

  // Right shift that brings both components of a vector below 2^15.
  function automatic logic [4:0] red_shift(input logic [32:0] m);
    logic [5:0] len;
    len = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) begin
        len = 6'(i + 1);
      end
    end
    return (len > 6'd15) ? 5'(len - 6'd15) : 5'd0;
  endfunction

  // Shifted magnitude with the sign put back, as a 16-bit two's complement value.
  function automatic logic [15:0] red_apply(input logic neg, input logic [32:0] m,
                                            input logic [4:0] sh);
    logic [32:0] s;
    s = m >> sh;
    return neg ? (16'd0 - s[15:0]) : s[15:0];
  endfunction

  function automatic logic [31:0] mul_s16(input logic [15:0] a, input logic [15:0] b);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    sa = {{16{a[15]}}, a};
    sb = {{16{b[15]}}, b};
    return 32'(sa * sb);
  endfunction

  // Saturate a 43-bit two's complement sum to the 32-bit signed range.
  function automatic logic [31:0] sat32(input logic [42:0] s);
    logic [31:0] r;
    if (!s[42] && (|s[41:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (s[42] && !(&s[41:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/circle_pair_collision_response_unit.sv =====
// Top level of the circle pair collision response unit: a single deep pipeline.
// Depends on cpcr_pkg for constants and arithmetic helpers.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  in_tdata: one circle pair
// out_     master     out_tvalid/out_tready out_tdata: new velocities, out_tuser: collided
//
// One pair enters per cycle while in_tready is high; the pipeline depth is set by the
// 31-step square root, the cosine divide and the 41-step momentum divide, each of which
// takes one stage per step.
// Reset clears the valid bits of all stages and the output register; payload is not reset.
// When the output register holds a result that is not taken, every stage halts together and
// in_tready falls, so nothing is lost or repeated.

module circle_pair_collision_response_unit
  import cpcr_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata, lowest bit up: a_pos_x, a_pos_y, b_pos_x, b_pos_y (32 each), a_radius,
  // b_radius (31 each), a_vel_x, a_vel_y, b_vel_x, b_vel_y, a_mass, b_mass (32 each), zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata, lowest bit up: a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: collided
  output logic                   out_tuser
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned KPW = 33 + F;
  localparam int unsigned NW  = 65 + F;

  localparam int unsigned ST_DIF = 1;
  localparam int unsigned ST_ABS = 2;
  localparam int unsigned ST_SQ  = 3;
  localparam int unsigned ST_RED = 4;
  localparam int unsigned ST_PRD = 5;
  localparam int unsigned ST_DOT = 6;
  localparam int unsigned ST_NRM = 7;
  localparam int unsigned SQ0    = 8;
  localparam int unsigned DV0    = SQ0 + SQ_STEPS;
  localparam int unsigned KM1    = DV0 + F + 1;
  localparam int unsigned KM2    = KM1 + 1;
  localparam int unsigned HD0    = KM2 + 1;
  localparam int unsigned HDS    = HD0 + 1;
  localparam int unsigned ST_SUM = HDS + HD_STEPS;
  localparam int unsigned NST    = ST_SUM + 1;

  // Lanes 0..3 are a_x, a_y, b_x, b_y; index 0/1 of the two-way arrays is circle A/B.
  typedef struct packed {
    logic [31:0]           ax;
    logic [31:0]           ay;
    logic [31:0]           bx;
    logic [31:0]           by;
    logic [30:0]           ra;
    logic [30:0]           rb;
    logic [31:0]           a_m;
    logic [31:0]           b_m;
    logic [3:0][31:0]      vel;
    logic [3:0][31:0]      vm;
    logic [32:0]           dx;
    logic [32:0]           dy;
    logic [31:0]           rs;
    logic [32:0]           dmx;
    logic [32:0]           dmy;
    logic [63:0]           rsq;
    logic [3:0][63:0]      mv;
    logic [4:0]            sha;
    logic [4:0]            shb;
    logic [4:0]            shu;
    logic [65:0]           dsq_x;
    logic [65:0]           dsq_y;
    logic [77:0]           rsq_k;
    logic [66:0]           dsum;
    logic [80:0]           dsum_k;
    logic [15:0]           ux;
    logic [15:0]           uy;
    logic [15:0]           avx_r;
    logic [15:0]           avy_r;
    logic [15:0]           bvx_r;
    logic [15:0]           bvy_r;
    logic [31:0]           ua_x;
    logic [31:0]           ua_y;
    logic [31:0]           ub_x;
    logic [31:0]           ub_y;
    logic [31:0]           uu_x;
    logic [31:0]           uu_y;
    logic [31:0]           aa_x;
    logic [31:0]           aa_y;
    logic [31:0]           bb_x;
    logic [31:0]           bb_y;
    logic                  hit;
    logic [1:0][32:0]      dot;
    logic [31:0]           nu;
    logic [1:0][31:0]      nv;
    logic [1:0]            cz;
    logic [1:0][61:0]      sq_n;
    logic [1:0][34:0]      sq_rem;
    logic [1:0][30:0]      sq_root;
    logic [1:0][31:0]      cd_rem;
    logic [1:0][F:0]       cd_q;
    logic [3:0][KPW-1:0]   kp;
    logic [3:0][KPW-1:0]   hp_lo;
    logic [3:0][KPW-1:0]   hp_hi;
    logic [3:0][32:0]      kept;
    logic [3:0][63:0]      nsh;
    logic [3:0][31:0]      dmass;
    logic [3:0]            ovf;
    logic [3:0][31:0]      hrem;
    logic [3:0][40:0]      hnum;
    logic [3:0][42:0]      sum;
  } pipe_t;

  pipe_t                   pipe_r   [NST];
  pipe_t                   pipe_nxt [NST];
  logic [NST-1:0]          vld_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [OUT_TDATA_W-1:0]  out_data_nxt;
  logic                    out_user_r;
  logic                    en;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    pipe_nxt[0]        = '0;
    pipe_nxt[0].ax     = in_tdata[31:0];
    pipe_nxt[0].ay     = in_tdata[63:32];
    pipe_nxt[0].bx     = in_tdata[95:64];
    pipe_nxt[0].by     = in_tdata[127:96];
    pipe_nxt[0].ra     = in_tdata[158:128];
    pipe_nxt[0].rb     = in_tdata[189:159];
    pipe_nxt[0].vel[0] = in_tdata[221:190];
    pipe_nxt[0].vel[1] = in_tdata[253:222];
    pipe_nxt[0].vel[2] = in_tdata[285:254];
    pipe_nxt[0].vel[3] = in_tdata[317:286];
    pipe_nxt[0].a_m    = in_tdata[349:318];
    pipe_nxt[0].b_m    = in_tdata[381:350];
  end

  for (genvar k = 1; k < NST; k++) begin : g_st
    always_comb begin
      pipe_t          p;
      pipe_t          n;
      logic [34:0]    rem2;
      logic [34:0]    trial;
      logic [31:0]    t32;
      logic [32:0]    t33;
      logic [30:0]    den;
      logic           ge;
      logic [1:0][F:0] cs;
      logic [F:0]     ck;
      logic [F:0]     ch;
      logic [F:0]     onec;
      logic [KPW-1:0] kmag;
      logic [NW-1:0]  nw;
      logic [31:0]    md;
      logic [40:0]    q;
      logic [42:0]    hs;
      p     = pipe_r[k-1];
      n     = p;
      rem2  = '0;
      trial = '0;
      t32   = '0;
      t33   = '0;
      den   = '0;
      ge    = 1'b0;
      cs    = '0;
      ck    = '0;
      ch    = '0;
      onec  = '0;
      kmag  = '0;
      nw    = '0;
      md    = '0;
      q     = '0;
      hs    = '0;
      if (k == ST_DIF) begin
        n.dx = {p.bx[31], p.bx} - {p.ax[31], p.ax};
        n.dy = {p.by[31], p.by} - {p.ay[31], p.ay};
        n.rs = {1'b0, p.ra} + {1'b0, p.rb};
        for (int i = 0; i < 4; i++) begin
          n.vm[i] = p.vel[i][31] ? (32'd0 - p.vel[i]) : p.vel[i];
        end
      end else if (k == ST_ABS) begin
        n.dmx = p.dx[32] ? (33'd0 - p.dx) : p.dx;
        n.dmy = p.dy[32] ? (33'd0 - p.dy) : p.dy;
        n.rsq = {32'd0, p.rs} * {32'd0, p.rs};
        // Momentum of the sending circle, mass times speed, for each receiving lane.
        for (int i = 0; i < 4; i++) begin
          md      = (i < 2) ? p.b_m : p.a_m;
          n.mv[i] = {32'd0, md} * {32'd0, p.vm[i ^ 2]};
        end
        n.sha = red_shift({1'b0, p.vm[0] | p.vm[1]});
        n.shb = red_shift({1'b0, p.vm[2] | p.vm[3]});
      end else if (k == ST_SQ) begin
        n.dsq_x = {33'd0, p.dmx} * {33'd0, p.dmx};
        n.dsq_y = {33'd0, p.dmy} * {33'd0, p.dmy};
        n.rsq_k = {14'd0, p.rsq} * {64'd0, K_RAD};
        n.shu   = red_shift(p.dmx | p.dmy);
        n.avx_r = red_apply(p.vel[0][31], {1'b0, p.vm[0]}, p.sha);
        n.avy_r = red_apply(p.vel[1][31], {1'b0, p.vm[1]}, p.sha);
        n.bvx_r = red_apply(p.vel[2][31], {1'b0, p.vm[2]}, p.shb);
        n.bvy_r = red_apply(p.vel[3][31], {1'b0, p.vm[3]}, p.shb);
      end else if (k == ST_RED) begin
        n.dsum = {1'b0, p.dsq_x} + {1'b0, p.dsq_y};
        n.ux   = red_apply(p.dx[32], p.dmx, p.shu);
        n.uy   = red_apply(p.dy[32], p.dmy, p.shu);
      end else if (k == ST_PRD) begin
        n.dsum_k = {14'd0, p.dsum} * {67'd0, K_DIST};
        n.ua_x   = mul_s16(p.ux, p.avx_r);
        n.ua_y   = mul_s16(p.uy, p.avy_r);
        n.ub_x   = mul_s16(p.ux, p.bvx_r);
        n.ub_y   = mul_s16(p.uy, p.bvy_r);
        n.uu_x   = mul_s16(p.ux, p.ux);
        n.uu_y   = mul_s16(p.uy, p.uy);
        n.aa_x   = mul_s16(p.avx_r, p.avx_r);
        n.aa_y   = mul_s16(p.avy_r, p.avy_r);
        n.bb_x   = mul_s16(p.bvx_r, p.bvx_r);
        n.bb_y   = mul_s16(p.bvy_r, p.bvy_r);
      end else if (k == ST_DOT) begin
        n.hit    = p.dsum_k <= {3'd0, p.rsq_k};
        n.dot[0] = {p.ua_x[31], p.ua_x} + {p.ua_y[31], p.ua_y};
        // Circle B looks along the reversed centre line.
        n.dot[1] = 33'd0 - ({p.ub_x[31], p.ub_x} + {p.ub_y[31], p.ub_y});
        n.nu     = p.uu_x + p.uu_y;
        n.nv[0]  = p.aa_x + p.aa_y;
        n.nv[1]  = p.bb_x + p.bb_y;
      end else if (k == ST_NRM) begin
        for (int s = 0; s < 2; s++) begin
          n.sq_n[s]    = {31'd0, p.nu[30:0]} * {31'd0, p.nv[s][30:0]};
          n.cz[s]      = p.dot[s][32] || (p.dot[s] == 33'd0);
          n.sq_rem[s]  = '0;
          n.sq_root[s] = '0;
        end
      end else if (k >= SQ0 && k < DV0) begin
        // One root bit per stage from the next pair of radicand bits.
        for (int s = 0; s < 2; s++) begin
          rem2  = {p.sq_rem[s][32:0], p.sq_n[s][61:60]};
          trial = {2'b00, p.sq_root[s], 2'b01};
          ge    = rem2 >= trial;
          n.sq_rem[s]  = ge ? (rem2 - trial) : rem2;
          n.sq_root[s] = {p.sq_root[s][29:0], ge};
          n.sq_n[s]    = {p.sq_n[s][59:0], 2'b00};
        end
      end else if (k >= DV0 && k < KM1) begin
        // Cosine as dot * 2^F / den, one quotient bit per stage; it never exceeds 2^F.
        for (int s = 0; s < 2; s++) begin
          den = p.sq_root[s];
          t32 = (k == DV0) ? p.dot[s][31:0] : {p.cd_rem[s][30:0], 1'b0};
          ge  = t32 >= {1'b0, den};
          n.cd_rem[s] = ge ? (t32 - {1'b0, den}) : t32;
          n.cd_q[s]   = {p.cd_q[s][F-1:0], ge};
        end
      end else if (k == KM1) begin
        for (int s = 0; s < 2; s++) begin
          cs[s] = p.cz[s] ? '0 : p.cd_q[s];
        end
        for (int i = 0; i < 4; i++) begin
          ck   = (i < 2) ? cs[0] : cs[1];
          ch   = (i < 2) ? cs[1] : cs[0];
          onec = {1'b1, {F{1'b0}}} - ck;
          n.kp[i]    = {{(F + 1){1'b0}}, p.vm[i]} * {32'd0, onec};
          n.hp_lo[i] = {{(F + 1){1'b0}}, p.mv[i][31:0]} * {32'd0, ch};
          n.hp_hi[i] = {{(F + 1){1'b0}}, p.mv[i][63:32]} * {32'd0, ch};
        end
      end else if (k == KM2) begin
        for (int i = 0; i < 4; i++) begin
          kmag      = p.kp[i] >> F;
          n.kept[i] = p.vel[i][31] ? (33'd0 - {1'b0, kmag[31:0]}) : {1'b0, kmag[31:0]};
          nw        = {p.hp_hi[i], 32'd0} + {32'd0, p.hp_lo[i]};
          n.nsh[i]  = nw[F +: 64];
          md        = (i < 2) ? p.a_m : p.b_m;
          n.dmass[i] = (md == 32'd0) ? 32'd1 : md;
        end
      end else if (k == HD0) begin
        // A quotient of 2^41 or more is clamped anyway, so only 41 bits are divided out.
        for (int i = 0; i < 4; i++) begin
          n.ovf[i]  = {9'd0, p.nsh[i][63:41]} >= p.dmass[i];
          n.hrem[i] = {9'd0, p.nsh[i][63:41]};
          n.hnum[i] = p.nsh[i][40:0];
        end
      end else if (k >= HDS && k < ST_SUM) begin
        for (int i = 0; i < 4; i++) begin
          t33 = {p.hrem[i], p.hnum[i][40]};
          ge  = t33 >= {1'b0, p.dmass[i]};
          n.hrem[i] = ge ? 32'(t33 - {1'b0, p.dmass[i]}) : t33[31:0];
          n.hnum[i] = {p.hnum[i][39:0], ge};
        end
      end else if (k == ST_SUM) begin
        for (int i = 0; i < 4; i++) begin
          q  = (p.ovf[i] || (p.hnum[i] > HAND_LIM)) ? HAND_LIM : p.hnum[i];
          hs = p.vel[i ^ 2][31] ? (43'd0 - {2'b00, q}) : {2'b00, q};
          n.sum[i] = {{10{p.kept[i][32]}}, p.kept[i]} + hs;
        end
      end
      pipe_nxt[k] = n;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_data_nxt[32*i +: 32] = pipe_r[NST-1].hit ? sat32(pipe_r[NST-1].sum[i])
                                                   : pipe_r[NST-1].vel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], in_tvalid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
      out_data_r <= out_data_nxt;
      out_user_r <= pipe_r[NST-1].hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
